FILE: rtl/hdsn_pkg.sv
// Shared types, codes and constants of the image header dimension sniffer.
package hdsn_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_BYTES  = 2'd0,
        CFG_MAX_DIM    = 2'd1,
        CFG_MAX_PIXELS = 2'd2
    } cfg_idx_t;

    localparam logic [23:0] MAX_BYTES_RST  = 24'(8 * 1024 * 1024);
    localparam logic [15:0] MAX_DIM_RST    = 16'd16384;
    localparam logic [31:0] MAX_PIXELS_RST = 32'd67108864;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_TOO_LONG    = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_BAD_HEADER  = 3'd4,
        ST_OVER_LIMITS = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_PNG  = 2'd1,
        FMT_JPEG = 2'd2
    } format_t;

    // JPEG marker walk phases
    typedef enum logic [5:0] {
        PH_FF     = 6'b000001,
        PH_MARKER = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_LEN_LO = 6'b001000,
        PH_SOF    = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    localparam logic [7:0] PNG_SIG [0:7] =
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    // last entry is padding, only the first three are compared
    localparam logic [7:0] JPG_SIG [0:3] = '{8'hFF, 8'hD8, 8'hFF, 8'h00};

    localparam logic [7:0] MK_FF   = 8'hFF;
    localparam logic [7:0] MK_FILL = 8'h00;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_SOF0 = 8'hC0;
    localparam logic [7:0] MK_SOFF = 8'hCF;
    localparam logic [7:0] MK_DHT  = 8'hC4;
    localparam logic [7:0] MK_JPG  = 8'hC8;
    localparam logic [7:0] MK_DAC  = 8'hCC;

    // File state at its final byte, as the verdict logic needs it
    typedef struct packed {
        logic        over_cap;
        logic        lt8;
        logic        lt24;
        logic [1:0]  mismatch;   // bit 0 PNG signature, bit 1 JPEG start
        logic        walk_ok;
        logic [31:0] raw_w;
        logic [31:0] raw_h;
    } snap_t;

    typedef struct packed {
        logic [15:0] height;
        logic [15:0] width;
        format_t     format;
        status_t     status;
    } result_t;

    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m >= MK_SOF0) && (m <= MK_SOFF) && (m != MK_DHT) &&
               (m != MK_JPG) && (m != MK_DAC);
    endfunction

endpackage

FILE: rtl/hdsn_parse.sv
// Per-byte file state: byte count, signature checks, PNG fields and JPEG marker walk.
module hdsn_parse
    import hdsn_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [23:0] max_bytes,
    output snap_t       snap
);

    localparam int CMPW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
    localparam int NW   = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  over_cap_reg, over_cap_next;
    logic [1:0]            fs_reg, fs_next;
    logic [COUNT_BITS-1:0] nmp_reg, nmp_next;
    phase_t                phase_reg, phase_next;
    logic [7:0]            seg_hi_reg, seg_hi_next;
    logic                  wf_reg, wf_next;
    logic                  dims_reg, dims_next;
    logic                  tail_reg, tail_next;
    logic [31:0]           raw_w_reg, raw_w_next;
    logic [31:0]           raw_h_reg, raw_h_next;

    logic                  cap_hit;
    logic                  take;
    logic [15:0]           seg;
    logic [NW-1:0]         ni;
    logic [COUNT_BITS-1:0] off;
    logic                  in_png_dims;

    assign cap_hit = (CMPW'(count_reg) >= CMPW'(max_bytes)) || (&count_reg);
    assign take    = !over_cap_reg && !cap_hit;
    assign seg     = {seg_hi_reg, data_byte};
    assign ni      = NW'(nmp_reg) + NW'(seg) + NW'(2);
    assign off     = count_reg - nmp_reg;
    assign in_png_dims = (count_reg[COUNT_BITS-1:5] == '0) && count_reg[4] && !count_reg[3];

    always_comb
    begin
        count_next    = count_reg;
        over_cap_next = over_cap_reg | cap_hit;
        fs_next       = fs_reg;
        nmp_next      = nmp_reg;
        phase_next    = phase_reg;
        seg_hi_next   = seg_hi_reg;
        wf_next       = wf_reg;
        dims_next     = dims_reg;
        tail_next     = tail_reg;
        raw_w_next    = raw_w_reg;
        raw_h_next    = raw_h_reg;
        if (take)
        begin
            count_next = count_reg + 1'b1;
            if ((count_reg < COUNT_BITS'(8)) && (data_byte != PNG_SIG[count_reg[2:0]]))
                fs_next[0] = 1'b1;
            if ((count_reg < COUNT_BITS'(3)) && (data_byte != JPG_SIG[count_reg[1:0]]))
                fs_next[1] = 1'b1;
            if (dims_reg)
                tail_next = 1'b1;
            // big-endian width at 16..19, height at 20..23
            if (!fs_next[0] && in_png_dims)
            begin
                if (!count_reg[2])
                    raw_w_next = {raw_w_reg[23:0], data_byte};
                else
                    raw_h_next = {raw_h_reg[23:0], data_byte};
            end
            if (fs_next[0] && (count_reg >= COUNT_BITS'(2)) && !wf_reg && !dims_reg)
            begin
                unique case (phase_reg)
                    PH_FF:
                    begin
                        if (count_reg == nmp_reg)
                        begin
                            if (data_byte != MK_FF)
                                wf_next = 1'b1;
                            else
                                phase_next = PH_MARKER;
                        end
                    end
                    PH_MARKER:
                    begin
                        if ((data_byte == MK_FILL) || (data_byte == MK_FF))
                        begin
                            nmp_next = count_reg;
                            if (data_byte == MK_FILL)
                                wf_next = 1'b1;
                        end
                        else if ((data_byte == MK_SOI) || (data_byte == MK_EOI))
                        begin
                            nmp_next   = nmp_reg + COUNT_BITS'(2);
                            phase_next = PH_FF;
                        end
                        else if (is_frame_marker(data_byte))
                            phase_next = PH_SOF;
                        else
                            phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        seg_hi_next = data_byte;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if (seg < 16'd2)
                            wf_next = 1'b1;
                        else if (ni[NW-1:COUNT_BITS] != '0)
                            wf_next = 1'b1;
                        else
                        begin
                            nmp_next   = ni[COUNT_BITS-1:0];
                            phase_next = PH_FF;
                        end
                    end
                    PH_SOF:
                    begin
                        // height at marker+5..6, width at marker+7..8
                        if ((off == COUNT_BITS'(5)) || (off == COUNT_BITS'(6)))
                            raw_h_next = {16'h0000, raw_h_reg[7:0], data_byte};
                        else if ((off == COUNT_BITS'(7)) || (off == COUNT_BITS'(8)))
                            raw_w_next = {16'h0000, raw_w_reg[7:0], data_byte};
                        if (off >= COUNT_BITS'(8))
                        begin
                            dims_next  = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        snap.over_cap = over_cap_next;
        snap.lt8      = count_next < COUNT_BITS'(8);
        snap.lt24     = count_next < COUNT_BITS'(24);
        snap.mismatch = fs_next;
        snap.walk_ok  = dims_next && !wf_next && tail_next;
        snap.raw_w    = raw_w_next;
        snap.raw_h    = raw_h_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            over_cap_reg <= 1'b0;
            fs_reg       <= '0;
            nmp_reg      <= COUNT_BITS'(2);
            phase_reg    <= PH_FF;
            seg_hi_reg   <= '0;
            wf_reg       <= 1'b0;
            dims_reg     <= 1'b0;
            tail_reg     <= 1'b0;
            raw_w_reg    <= '0;
            raw_h_reg    <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                count_reg    <= '0;
                over_cap_reg <= 1'b0;
                fs_reg       <= '0;
                nmp_reg      <= COUNT_BITS'(2);
                phase_reg    <= PH_FF;
                seg_hi_reg   <= '0;
                wf_reg       <= 1'b0;
                dims_reg     <= 1'b0;
                tail_reg     <= 1'b0;
                raw_w_reg    <= '0;
                raw_h_reg    <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                over_cap_reg <= over_cap_next;
                fs_reg       <= fs_next;
                nmp_reg      <= nmp_next;
                phase_reg    <= phase_next;
                seg_hi_reg   <= seg_hi_next;
                wf_reg       <= wf_next;
                dims_reg     <= dims_next;
                tail_reg     <= tail_next;
                raw_w_reg    <= raw_w_next;
                raw_h_reg    <= raw_h_next;
            end
        end
    end

endmodule

FILE: rtl/hdsn_eval.sv
// Verdict for one finished file: status, format and checked dimensions.
module hdsn_eval
    import hdsn_pkg::*;
(
    input  snap_t       snap,
    input  logic [15:0] max_dim,
    input  logic [31:0] max_pixels,
    output result_t     res
);

    logic [31:0] area;
    logic        good;
    logic        over;
    format_t     fmt;

    // only meaningful when both sides fit max_dim, i.e. in 16 bits
    assign area = snap.raw_w[15:0] * snap.raw_h[15:0];

    always_comb
    begin
        if (!snap.mismatch[0])
            fmt = FMT_PNG;
        else if (!snap.mismatch[1])
            fmt = FMT_JPEG;
        else
            fmt = FMT_NONE;

        if (fmt == FMT_PNG)
            good = (snap.raw_w != '0) && (snap.raw_h != '0) &&
                   !snap.raw_w[31] && !snap.raw_h[31];
        else
            good = snap.walk_ok && (snap.raw_w != '0) && (snap.raw_h != '0);

        over = (snap.raw_w > {16'h0000, max_dim}) || (snap.raw_h > {16'h0000, max_dim}) ||
               (area > max_pixels);

        res.status = ST_OK;
        res.format = FMT_NONE;
        res.width  = '0;
        res.height = '0;
        if (snap.over_cap)
            res.status = ST_TOO_LONG;
        else if (snap.lt8 || (fmt == FMT_NONE))
            res.status = ST_UNSUPPORTED;
        else
        begin
            res.format = fmt;
            if (snap.lt24 || !good)
                res.status = ST_BAD_HEADER;
            else if (over)
                res.status = ST_OVER_LIMITS;
            else
            begin
                res.width  = snap.raw_w[15:0];
                res.height = snap.raw_h[15:0];
            end
        end
    end

endmodule

FILE: rtl/image_header_dimension_sniffer.sv
// Top level: input register, file state, snapshot register, verdict and result register.
//
//  channel  | dir | fields (lowest bit first)                 | transfer
//  ---------+-----+-------------------------------------------+---------------------
//  s_*      | in  | tdata: data_byte[7:0]; tlast: last_byte   | s_tvalid & s_tready
//  m_*      | out | tdata: status[2:0] format[4:3]            | m_tvalid & m_tready
//           |     |        width[20:5] height[36:21], pad     |
//  cfg_*    | in  | index 0 max_bytes, 1 max_dim, 2 max_pixels| cfg_we
//
// One byte is taken every cycle while no last byte waits; the byte state updates from the input register.
// A file's result passes from the input register through the snapshot and result registers before it is offered.
// Only a last byte waits, for the snapshot register to free up; the input stalls behind it.
// Reset clears the file state and loads the default limits; no clearing pass is needed.
module image_header_dimension_sniffer
    import hdsn_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // status[2:0], format[4:3], width[20:5], height[36:21]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [23:0] max_bytes_reg;
    logic [15:0] max_dim_reg;
    logic [31:0] max_pixels_reg;

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;

    logic        snap_valid_reg;
    snap_t       snap_reg;
    snap_t       snap_next;

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     res_next;

    logic        out_load;
    logic        snap_free;
    logic        step;

    assign out_load  = snap_valid_reg && (!out_valid_reg || m_tready);
    assign snap_free = !snap_valid_reg || out_load;
    assign step      = in_valid_reg && (!in_last_reg || snap_free);
    assign s_tready  = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg  <= MAX_BYTES_RST;
            max_dim_reg    <= MAX_DIM_RST;
            max_pixels_reg <= MAX_PIXELS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_BYTES:  max_bytes_reg  <= cfg_data[23:0];
                CFG_MAX_DIM:    max_dim_reg    <= cfg_data[15:0];
                CFG_MAX_PIXELS: max_pixels_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hdsn_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .max_bytes (max_bytes_reg),
        .snap      (snap_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (snap_free)
            snap_valid_reg <= step && in_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
            snap_reg <= snap_next;
    end

    hdsn_eval u_eval (
        .snap       (snap_reg),
        .max_dim    (max_dim_reg),
        .max_pixels (max_pixels_reg),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.height, out_reg.width, out_reg.format, out_reg.status};

endmodule

FILE: rtl/hdsn_checker.sv
// Port-level checks for the sniffer and their binding to the top level.
module hdsn_port_checks
    import hdsn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata
);

    // a held result stays put until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // empty and undefined codes never appear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == ST_OK) || (m_tdata[2:0] == ST_TOO_LONG) ||
                     (m_tdata[2:0] == ST_UNSUPPORTED) || (m_tdata[2:0] == ST_BAD_HEADER) ||
                     (m_tdata[2:0] == ST_OVER_LIMITS))
    else $error("illegal status code");

    // an accepted image has a known format and non-zero dimensions
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == ST_OK) |->
            (m_tdata[4:3] != FMT_NONE) && (m_tdata[20:5] != '0) && (m_tdata[36:21] != '0))
    else $error("ok result without format or dimensions");

    // rejected images carry no dimensions; length and format failures carry no format
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_OK) |->
            (m_tdata[36:5] == '0) &&
            (((m_tdata[2:0] != ST_TOO_LONG) && (m_tdata[2:0] != ST_UNSUPPORTED)) ||
             (m_tdata[4:3] == FMT_NONE)))
    else $error("rejected result carries format or dimensions");

    // nothing is offered straight out of reset
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
    else $error("result offered during reset");

endmodule

bind image_header_dimension_sniffer hdsn_port_checks u_hdsn_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: bench/hdsn_checker.sv
// Checker for the image header dimension sniffer: predicts each file's verdict and compares.
module hdsn_checker
    import hdsn_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // status[2:0], format[4:3], width[20:5], height[36:21]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          error_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [7:0] PNG_MAGIC [8] =
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] JPEG_MAGIC [3] = '{8'hFF, 8'hD8, 8'hFF};

    // limits as last written
    logic [23:0] lim_bytes;
    logic [15:0] lim_dim;
    logic [31:0] lim_pixels;

    // per-file state
    longint unsigned pos_count;
    bit              past_cap;
    logic [1:0]      sig_miss;      // bit 0 PNG signature broken, bit 1 JPEG start broken
    longint unsigned marker_pos;
    phase_t          phase;
    logic [15:0]     seg_len;
    longint unsigned frame_pos;
    bit              walk_bad;
    bit              frame_seen;
    logic [31:0]     img_w;
    logic [31:0]     img_h;

    result_t verdicts [$];

    function automatic void start_file();
        pos_count  = 0;
        past_cap   = 0;
        sig_miss   = 2'b00;
        marker_pos = 2;
        phase      = PH_FF;
        seg_len    = '0;
        frame_pos  = 0;
        walk_bad   = 0;
        frame_seen = 0;
        img_w      = '0;
        img_h      = '0;
    endfunction

    function automatic bit starts_frame(input logic [7:0] m);
        return m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
    endfunction

    // JPEG marker walk, one byte at a time
    function automatic void walk_step(input longint unsigned pos, input logic [7:0] b);
        longint unsigned skip_to;
        longint unsigned off;
        case (phase)
            PH_FF:
                if (pos == marker_pos)
                begin
                    if (b != 8'hFF)
                        walk_bad = 1;
                    else
                        phase = PH_MARKER;
                end
            PH_MARKER:
                if (b == 8'h00 || b == 8'hFF)
                begin
                    // fill byte: the marker now starts here
                    marker_pos = pos;
                    if (b == 8'h00)
                        walk_bad = 1;
                end
                else if (b == 8'hD8 || b == 8'hD9)
                begin
                    marker_pos = marker_pos + 2;
                    phase      = PH_FF;
                end
                else if (starts_frame(b))
                    phase = PH_SOF;
                else
                    phase = PH_LEN_HI;
            PH_LEN_HI:
            begin
                seg_len = {b, 8'h00};
                phase   = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                seg_len[7:0] = b;
                if (seg_len < 16'd2)
                    walk_bad = 1;
                else
                begin
                    skip_to = marker_pos + 2 + seg_len;
                    if (skip_to > COUNT_MAX)
                        walk_bad = 1;
                    else
                    begin
                        marker_pos = skip_to;
                        phase      = PH_FF;
                    end
                end
            end
            PH_SOF:
            begin
                off = pos - marker_pos;
                if (off == 5 || off == 6)
                    img_h = {16'h0000, img_h[7:0], b};
                else if (off == 7 || off == 8)
                    img_w = {16'h0000, img_w[7:0], b};
                if (off >= 8)
                begin
                    frame_seen = 1;
                    frame_pos  = marker_pos;
                    phase      = PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void take_byte(input longint unsigned pos, input logic [7:0] b);
        if (pos < 8 && b != PNG_MAGIC[int'(pos)])
            sig_miss[0] = 1'b1;
        if (pos < 3 && b != JPEG_MAGIC[int'(pos)])
            sig_miss[1] = 1'b1;
        if (!sig_miss[0] && pos >= 16 && pos < 24)
        begin
            if (pos < 20)
                img_w = {img_w[23:0], b};
            else
                img_h = {img_h[23:0], b};
        end
        if (sig_miss[0] && pos >= 2 && !walk_bad && !frame_seen)
            walk_step(pos, b);
    endfunction

    // Returns 1 when the byte closes a file, with its verdict in r.
    function automatic bit sniff_byte(input logic [7:0] b, input logic last,
                                      output result_t r);
        longint unsigned cap;
        longint unsigned n;
        bit              sane;
        status_t         st;
        format_t         fm;
        r   = '0;
        cap = (lim_bytes < COUNT_MAX) ? lim_bytes : COUNT_MAX;
        if (!past_cap)
        begin
            if (pos_count >= cap)
                past_cap = 1;
            else
            begin
                pos_count = pos_count + 1;
                take_byte(pos_count - 1, b);
            end
        end
        if (!last)
            return 0;

        n  = pos_count;
        fm = FMT_NONE;
        if (past_cap)
            st = ST_TOO_LONG;
        else if (n == 0)
            st = ST_EMPTY;
        else if (n < 8)
            st = ST_UNSUPPORTED;
        else
        begin
            if (!sig_miss[0])
                fm = FMT_PNG;
            else if (!sig_miss[1])
                fm = FMT_JPEG;
            if (fm == FMT_NONE)
                st = ST_UNSUPPORTED;
            else if (n < 24)
                st = ST_BAD_HEADER;
            else
            begin
                if (fm == FMT_PNG)
                    sane = img_w != 0 && img_h != 0 && !img_w[31] && !img_h[31];
                else
                    sane = frame_seen && !walk_bad && frame_pos + 9 < n &&
                           img_w != 0 && img_h != 0;
                if (!sane)
                    st = ST_BAD_HEADER;
                else if (img_w > lim_dim || img_h > lim_dim ||
                         64'(img_w) * 64'(img_h) > 64'(lim_pixels))
                    st = ST_OVER_LIMITS;
                else
                begin
                    st       = ST_OK;
                    r.width  = img_w[15:0];
                    r.height = img_h[15:0];
                end
            end
        end
        r.status = st;
        r.format = fm;
        start_file();
        return 1;
    endfunction

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t due;
        result_t seen;
        if (!rst_n)
        begin
            lim_bytes  = MAX_BYTES_RST;
            lim_dim    = MAX_DIM_RST;
            lim_pixels = MAX_PIXELS_RST;
            start_file();
            verdicts.delete();
            error_count = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_MAX_BYTES:  lim_bytes  = cfg_data[23:0];
                    CFG_MAX_DIM:    lim_dim    = cfg_data[15:0];
                    CFG_MAX_PIXELS: lim_pixels = cfg_data;
                    default: ;
                endcase
            if (s_tvalid && s_tready)
            begin
                if (sniff_byte(s_tdata, s_tlast, due))
                    verdicts.push_back(due);
            end
            if (m_tvalid && m_tready)
            begin
                if (verdicts.size() == 0)
                begin
                    $error("result transfer with no file outstanding: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    due  = verdicts.pop_front();
                    seen = result_t'(m_tdata[36:0]);
                    match_field("status", 32'(due.status), 32'(seen.status));
                    match_field("format", 32'(due.format), 32'(seen.format));
                    match_field("width", 32'(due.width), 32'(seen.width));
                    match_field("height", 32'(due.height), 32'(seen.height));
                    match_field("pad", 32'd0, 32'(m_tdata[39:37]));
                end
            end
        end
        pending_results = verdicts.size();
    end

endmodule

FILE: bench/tb_image_header_dimension_sniffer.sv
// Testbench top for the image header dimension sniffer: file stimulus, limits and verdict.
module tb_image_header_dimension_sniffer;
    timeunit 1ns;
    timeprecision 1ps;
    import hdsn_pkg::*;

    localparam int COUNT_BITS     = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {IMG_PNG, IMG_JPEG, IMG_NOISE} image_kind_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;    // data_byte[7:0]
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;              // status[2:0], format[4:3], width[20:5], height[36:21]
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_MAX_BYTES;
    logic [31:0] cfg_data  = 32'h0;

    int          error_count;
    int          pending_results;
    int          sent_bytes   = 0;
    int unsigned quiet_cycles = 0;
    bit          hold_rx      = 1'b0;
    logic [15:0] cur_dim      = MAX_DIM_RST;
    logic [7:0]  img [$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    image_header_dimension_sniffer #(.COUNT_BITS(COUNT_BITS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hdsn_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    function automatic logic [31:0] pick_dim(input bit wide);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom_range(1, 16);
            2: return 32'(cur_dim) + $urandom_range(0, 2) - 32'd1;
            3: return $urandom_range(1, 255);
            4: return wide ? $urandom : $urandom_range(0, 16'hFFFF);
            default: return wide ? (32'h8000_0000 | $urandom) : 32'h0000_FFFF;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last, input bit steady);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_file(input bit steady);
        foreach (img[k])
            send_byte(img[k], k == img.size() - 1, steady);
    endtask

    // Builds one file into img; broken files carry one fault in the header.
    task automatic build_image(input image_kind_t kind, input bit broken, input int noise_max);
        logic [31:0] w;
        logic [31:0] h;
        logic [7:0]  mark;
        int          nseg;
        int          bad_at;
        int          fault;
        int          seg_len;
        int          keep;
        img.delete();
        case (kind)
            IMG_PNG:
            begin
                img = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
                if (broken)
                begin
                    keep      = $urandom_range(0, 7);
                    img[keep] = img[keep] ^ 8'(1 << $urandom_range(0, 7));
                end
                repeat (8) img.push_back(8'($urandom));
                w = pick_dim(1'b1);
                h = pick_dim(1'b1);
                for (int k = 3; k >= 0; k--)
                    img.push_back(w[8*k +: 8]);
                for (int k = 3; k >= 0; k--)
                    img.push_back(h[8*k +: 8]);
                repeat ($urandom_range(0, 8)) img.push_back(8'($urandom));
                // now and then cut the header short
                if ($urandom_range(0, 5) == 0)
                begin
                    keep = $urandom_range(9, 23);
                    while (img.size() > keep)
                        void'(img.pop_back());
                end
            end
            IMG_JPEG:
            begin
                img    = {8'hFF, 8'hD8, 8'hFF};
                nseg   = $urandom_range(1, 3);
                bad_at = broken ? $urandom_range(0, nseg - 1) : -1;
                fault  = $urandom_range(0, 4);
                for (int k = 0; k < nseg; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2)) img.push_back(8'hFF);
                    if (k == bad_at && fault == 0)
                        img.push_back(8'h00);
                    else if ($urandom_range(0, 3) == 0)
                        img.push_back($urandom_range(0, 1) ? 8'hD8 : 8'hD9);
                    else
                    begin
                        // segments that look like frames but are not, now and then
                        if ($urandom_range(0, 3) == 0)
                            mark = 8'hC4 + 8'(4 * $urandom_range(0, 2));
                        else
                        begin
                            do
                                mark = 8'($urandom_range(1, 254));
                            while (mark == 8'hD8 || mark == 8'hD9 ||
                                   (mark >= 8'hC0 && mark <= 8'hCF));
                        end
                        if (k == bad_at && fault == 2)
                            seg_len = $urandom_range(0, 1);
                        else if (k == bad_at && fault == 3)
                            seg_len = $urandom_range(256, 65535);
                        else
                            seg_len = $urandom_range(2, 10);
                        img.push_back(mark);
                        img.push_back(8'(seg_len >> 8));
                        img.push_back(8'(seg_len));
                        if (seg_len <= 10)
                            repeat (seg_len > 2 ? seg_len - 2 : 0) img.push_back(8'($urandom));
                        else
                            repeat ($urandom_range(0, 6)) img.push_back(8'($urandom));
                    end
                    img.push_back((k == bad_at && fault == 1) ?
                                  8'($urandom_range(0, 254)) : 8'hFF);
                end
                do
                    mark = 8'($urandom_range(8'hC0, 8'hCF));
                while (mark == 8'hC4 || mark == 8'hC8 || mark == 8'hCC);
                w = pick_dim(1'b0);
                h = pick_dim(1'b0);
                img.push_back(mark);
                img.push_back(8'h00);
                img.push_back(8'h11);
                img.push_back(8'h08);
                img.push_back(h[15:8]);
                img.push_back(h[7:0]);
                img.push_back(w[15:8]);
                img.push_back(w[7:0]);
                // no tail at all leaves the frame marker too close to the end
                repeat ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 6))
                    img.push_back(8'($urandom));
                if ($urandom_range(0, 4) != 0)
                    while (img.size() < 24)
                        img.push_back(8'($urandom));
                if (broken && fault == 4)
                    repeat ($urandom_range(1, 8)) void'(img.pop_back());
            end
            default:
            begin
                if ($urandom_range(0, 2) == 0)
                    img = {8'hFF, 8'hD8, 8'hFF};
                repeat ($urandom_range(1, noise_max)) img.push_back(8'($urandom));
            end
        endcase
    endtask

    task automatic random_files(input int byte_goal);
        int first;
        first = sent_bytes;
        while (sent_bytes - first < byte_goal)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: build_image(IMG_JPEG, $urandom_range(0, 3) == 0, 0);
                4, 5, 6:    build_image(IMG_PNG, $urandom_range(0, 4) == 0, 0);
                default:    build_image(IMG_NOISE, 1'b0, 30);
            endcase
            send_file($urandom_range(0, 3) == 0);
        end
    endtask

    // Lets every outstanding result drain before the limits change or the run ends.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_limits(input logic [23:0] bytes_cap, input logic [15:0] dim_cap,
                              input logic [31:0] pixel_cap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_BYTES;
        cfg_data  <= {8'($urandom), bytes_cap};
        @(negedge clk);
        cfg_index <= CFG_MAX_DIM;
        cfg_data  <= {16'($urandom), dim_cap};
        @(negedge clk);
        cfg_index <= CFG_MAX_PIXELS;
        cfg_data  <= pixel_cap;
        @(negedge clk);
        cfg_we  <= 1'b0;
        cur_dim = dim_cap;
    endtask

    initial
    begin : result_sink
        int gap;
        bit rx_steady;
        rx_steady = 1'b0;
        forever
        begin
            if (hold_rx)
            begin
                // long hold-off so the block backs up and stalls its input
                m_tready <= 1'b0;
                repeat (250) @(negedge clk);
                hold_rx = 1'b0;
            end
            if ($urandom_range(0, 7) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : byte_source
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one-byte file, bare JPEG start, bare PNG signature, JPEG frame in a short file
        img = {8'h00};
        send_file(1'b0);
        img = {8'hFF, 8'hD8, 8'hFF};
        send_file(1'b0);
        img = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        send_file(1'b1);
        img = {8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h11, 8'h08, 8'h00, 8'h02, 8'h00,
               8'h03, 8'h03};
        send_file(1'b0);
        random_files(300);

        settle();
        set_limits(24'hFF_FFFF, 16'hFFFF, 32'hFFFE_0001);
        random_files(300);

        settle();
        set_limits(24'd1, 16'd1, 32'd1);
        random_files(80);

        settle();
        set_limits(24'($urandom_range(20, 40)), 16'($urandom_range(1, 300)),
                   $urandom_range(1, 40000));
        hold_rx = 1'b1;
        repeat (24)
        begin
            build_image(IMG_NOISE, 1'b0, 2);
            send_file(1'b1);
        end
        random_files(350);

        settle();
        set_limits(MAX_BYTES_RST, 16'($urandom_range(100, 1000)), $urandom_range(1000, 200000));
        random_files(350);

        settle();
        if (error_count == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
